// ===== rtl/core/rdc_lz_pkg.sv =====
// Shared types, codes and constants of the packed-stream decoder.
package rdc_lz_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 8192;
	localparam int unsigned SIZE_W = 24;
	localparam int unsigned CNT_W = 13;

	localparam logic [CNT_W-1:0] SHORT_RUN_BIAS = 13'd3;
	localparam logic [CNT_W-1:0] LONG_RUN_BIAS = 13'd19;
	localparam logic [CNT_W-1:0] LONG_COPY_BIAS = 13'd16;
	localparam logic [CNT_W-1:0] DIST_BIAS = 13'd3;
	localparam logic [4:0] CTRL_BITS = 5'd16;

	localparam logic [3:0] CODE_SHORT_RUN = 4'd0;
	localparam logic [3:0] CODE_LONG_RUN = 4'd1;
	localparam logic [3:0] CODE_LONG_COPY = 4'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_ADV = 1'b1;

	localparam logic CFG_PACKED_SIZE = 1'b0;
	localparam logic CFG_RAW_SIZE = 1'b1;

	localparam logic [1:0] WANT_BYTE = 2'd0;
	localparam logic [1:0] WANT_ADV = 2'd1;
	localparam logic [1:0] WANT_DONE = 2'd2;
	localparam logic [1:0] WANT_ERR = 2'd3;

	typedef enum logic [3:0] {
		PH_FLAG = 4'd0,
		PH_CTRL_HI = 4'd1,
		PH_CTRL_LO = 4'd2,
		PH_LIT = 4'd3,
		PH_TOKEN = 4'd4,
		PH_RS_CHAR = 4'd5,
		PH_RL_HI = 4'd6,
		PH_RL_CHAR = 4'd7,
		PH_CP_DIST = 4'd8,
		PH_CP_LONG = 4'd9,
		PH_RUN = 4'd10,
		PH_COPY = 4'd11,
		PH_END = 4'd12
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [15:0] cw;
		logic [4:0] bits;
		logic err;
	} dec_state_t;

	typedef struct packed {
		logic has_byte;
		logic from_mem;
		logic [7:0] lit;
		logic [1:0] want;
	} res_t;

endpackage

// ===== rtl/core/rdc_lz_win_mem.sv =====
// History window: one write port, one read port with registered data.
module rdc_lz_win_mem #(
	parameter int unsigned DEPTH = rdc_lz_pkg::WINDOW_DEPTH_DEF,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [7:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/rdc_lz_ctrl.sv =====
// Token decoder: control word, counters, run and copy sequencing, window addressing.
module rdc_lz_ctrl #(
	parameter int unsigned WINDOW_DEPTH = rdc_lz_pkg::WINDOW_DEPTH_DEF,
	parameter int unsigned AW = $clog2(WINDOW_DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic in_acc,
	input logic op,
	input logic [7:0] byte_in,
	input logic cfg_we,
	input logic cfg_index,
	input logic [rdc_lz_pkg::SIZE_W-1:0] cfg_wdata,
	output logic rd_en,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_addr,
	output rdc_lz_pkg::res_t res
);
	import rdc_lz_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
	localparam logic [AW-1:0] DEPTH_A = AW'(WINDOW_DEPTH);
	localparam logic [16:0] DEPTH_W = 17'(WINDOW_DEPTH);

	function automatic dec_state_t settle(input dec_state_t s, input logic [SIZE_W-1:0] oc,
		input logic [SIZE_W-1:0] pc, input logic [SIZE_W-1:0] raw_sz,
		input logic [SIZE_W-1:0] pk_sz);
		dec_state_t r;
		r = s;
		if (r.phase == PH_FLAG) begin
			if (oc == raw_sz) begin
				r.phase = PH_END;
			end else if (r.bits == 5'd0) begin
				r.phase = PH_CTRL_HI;
			end else begin
				r.phase = r.cw[15] ? PH_TOKEN : PH_LIT;
				r.cw = {r.cw[14:0], 1'b0};
				r.bits = r.bits - 5'd1;
			end
		end
		if (r.phase == PH_CTRL_HI) begin
			if ({1'b0, pc} + 25'd1 >= {1'b0, pk_sz}) begin
				r.err = 1'b1;
				r.phase = PH_END;
			end
		end else if (r.phase inside {[PH_CTRL_LO:PH_CP_LONG]}) begin
			if (pc >= pk_sz) begin
				r.err = 1'b1;
				r.phase = PH_END;
			end
		end
		return r;
	endfunction

	dec_state_t st_q, st_a, st_n, st_b;
	logic [SIZE_W-1:0] pk_size_q, raw_size_q;
	logic [SIZE_W-1:0] pc_q, pc_n, oc_q, oc_n;
	logic [AW-1:0] wp_q, wp_n;
	logic [3:0] code_q, code_n;
	logic [CNT_W-1:0] rr_q, rr_n, dist_q, dist_n;
	logic [7:0] fill_q, fill_n;
	logic over_raw, too_far;
	logic [AW-1:0] dist_mod;
	logic emit_byte, emit_mem;
	logic [7:0] emit_lit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_size_q <= '0;
			raw_size_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PACKED_SIZE) begin
				pk_size_q <= cfg_wdata;
			end else begin
				raw_size_q <= cfg_wdata;
			end
		end
	end

	// source address of a copy, distance taken modulo the window depth
	always_comb begin
		dist_mod = (17'(dist_q) == DEPTH_W) ? '0 : AW'(dist_q);
		if (wp_q >= dist_mod) begin
			rd_addr = wp_q - dist_mod;
		end else begin
			rd_addr = wp_q + DEPTH_A - dist_mod;
		end
	end

	assign wr_addr = wp_q;

	always_comb begin
		st_a = settle(st_q, oc_q, pc_q, raw_size_q, pk_size_q);
		st_n = st_a;
		pc_n = pc_q;
		oc_n = oc_q;
		wp_n = wp_q;
		code_n = code_q;
		rr_n = rr_q;
		dist_n = dist_q;
		fill_n = fill_q;
		emit_byte = 1'b0;
		emit_mem = 1'b0;
		emit_lit = 8'd0;
		over_raw = 1'b0;
		too_far = 1'b0;

		if (op == OP_BYTE && st_a.phase inside {[PH_CTRL_HI:PH_CP_LONG]}) begin
			pc_n = pc_q + 24'd1;
			case (st_a.phase)
				PH_CTRL_HI: begin
					st_n.cw = {byte_in, 8'h00};
					st_n.phase = PH_CTRL_LO;
				end
				PH_CTRL_LO: begin
					st_n.cw = {st_a.cw[15:8], byte_in};
					st_n.bits = CTRL_BITS;
					st_n.phase = PH_FLAG;
				end
				PH_LIT: begin
					emit_byte = 1'b1;
					emit_lit = byte_in;
					st_n.phase = PH_FLAG;
				end
				PH_TOKEN: begin
					code_n = byte_in[7:4];
					if (byte_in[7:4] == CODE_SHORT_RUN) begin
						rr_n = {9'd0, byte_in[3:0]} + SHORT_RUN_BIAS;
						st_n.phase = PH_RS_CHAR;
					end else if (byte_in[7:4] == CODE_LONG_RUN) begin
						rr_n = {9'd0, byte_in[3:0]};
						st_n.phase = PH_RL_HI;
					end else begin
						dist_n = {9'd0, byte_in[3:0]};
						st_n.phase = PH_CP_DIST;
					end
				end
				PH_RS_CHAR, PH_RL_CHAR: begin
					fill_n = byte_in;
					over_raw = {1'b0, oc_q} + 25'(rr_q) > {1'b0, raw_size_q};
					st_n.phase = PH_RUN;
				end
				PH_RL_HI: begin
					rr_n = {1'b0, byte_in, rr_q[3:0]} + LONG_RUN_BIAS;
					st_n.phase = PH_RL_CHAR;
				end
				PH_CP_DIST: begin
					dist_n = {1'b0, byte_in, dist_q[3:0]} + DIST_BIAS;
					if (code_q == CODE_LONG_COPY) begin
						st_n.phase = PH_CP_LONG;
					end else begin
						rr_n = {9'd0, code_q};
						too_far = 24'(dist_n) > oc_q;
						over_raw = {1'b0, oc_q} + 25'(code_q) > {1'b0, raw_size_q};
						st_n.phase = PH_COPY;
					end
				end
				PH_CP_LONG: begin
					rr_n = {5'd0, byte_in} + LONG_COPY_BIAS;
					too_far = 24'(dist_q) > oc_q;
					over_raw = {1'b0, oc_q} + 25'(rr_n) > {1'b0, raw_size_q};
					st_n.phase = PH_COPY;
				end
				default: begin
					st_n.phase = st_a.phase;
				end
			endcase
			if (over_raw || too_far) begin
				st_n.err = 1'b1;
				st_n.phase = PH_END;
			end
		end else if (op == OP_ADV && (st_a.phase == PH_RUN || st_a.phase == PH_COPY)) begin
			emit_byte = 1'b1;
			if (st_a.phase == PH_RUN) begin
				emit_lit = fill_q;
			end else begin
				emit_mem = 1'b1;
			end
			rr_n = rr_q - 13'd1;
			if (rr_q == 13'd1) begin
				st_n.phase = PH_FLAG;
			end
		end

		// advance output count and window pointer on every emitted byte
		if (emit_byte) begin
			oc_n = oc_q + 24'd1;
			wp_n = (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
		end

		st_b = settle(st_n, oc_n, pc_n, raw_size_q, pk_size_q);
	end

	always_comb begin
		res.has_byte = emit_byte;
		res.from_mem = emit_mem;
		res.lit = emit_lit;
		rd_en = emit_mem & in_acc;
		if (st_b.phase == PH_END) begin
			res.want = st_b.err ? WANT_ERR : WANT_DONE;
		end else if (st_b.phase == PH_RUN || st_b.phase == PH_COPY) begin
			res.want = WANT_ADV;
		end else begin
			res.want = WANT_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_FLAG, cw: 16'd0, bits: 5'd0, err: 1'b0};
			pc_q <= '0;
			oc_q <= '0;
			wp_q <= '0;
			code_q <= '0;
			rr_q <= '0;
			dist_q <= '0;
			fill_q <= '0;
		end else if (in_acc) begin
			st_q <= st_b;
			pc_q <= pc_n;
			oc_q <= oc_n;
			wp_q <= wp_n;
			code_q <= code_n;
			rr_q <= rr_n;
			dist_q <= dist_n;
			fill_q <= fill_n;
		end
	end

endmodule

// ===== rtl/core/rdc_lz_rle_decompressor_core.sv =====
// A request's result is loaded into the output register as the request is accepted.
// One request per cycle unless the output stalls; the window has one read and one write
// port, and a copy byte is read at acceptance and written back when its result is taken.
// Reset clears the decoder state, counters, sizes and the output valid flag; the history
// window is not cleared and needs no clearing pass.
module rdc_lz_rle_decompressor_core #(
	parameter int unsigned WINDOW_DEPTH = rdc_lz_pkg::WINDOW_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic op,
	input logic [7:0] byte_in,
	output logic out_valid,
	input logic out_stall,
	output logic has_byte,
	output logic [7:0] out_byte,
	output logic [1:0] want,
	input logic cfg_we,
	input logic cfg_index,
	input logic [rdc_lz_pkg::SIZE_W-1:0] cfg_wdata
);
	import rdc_lz_pkg::*;

	localparam int unsigned AW = $clog2(WINDOW_DEPTH);

	logic in_acc, out_acc;
	logic rd_en;
	logic [AW-1:0] rd_addr, wr_addr, wr_addr_q;
	logic [7:0] rdata;
	res_t res, res_q;
	logic out_valid_q;

	assign in_stall = out_valid_q & out_stall;
	assign in_acc = in_valid & ~in_stall;
	assign out_acc = out_valid_q & ~out_stall;

	rdc_lz_ctrl #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_acc(in_acc),
		.op(op),
		.byte_in(byte_in),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.res(res)
	);

	// write the byte back into the window as its result leaves
	rdc_lz_win_mem #(
		.DEPTH(WINDOW_DEPTH),
		.AW(AW)
	) u_win (
		.clk(clk),
		.we(out_acc & res_q.has_byte),
		.waddr(wr_addr_q),
		.wdata(out_byte),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res;
			wr_addr_q <= wr_addr;
		end
	end

	assign out_valid = out_valid_q;
	assign has_byte = res_q.has_byte;
	assign out_byte = res_q.from_mem ? rdata : res_q.lit;
	assign want = res_q.want;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the packed-stream run/copy decoder core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rdc_lz_pkg::*;

	localparam logic [3:0] CODE_SHORT_COPY_MIN = 4'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic has_byte;
		logic [7:0] data;
		logic [1:0] want;
	} decoded_t;

	typedef enum int {
		END_DONE,
		END_TRUNCATED,
		END_OVERFLOW,
		END_TOO_FAR
	} ending_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic op;
	logic [7:0] byte_in;
	logic out_valid;
	logic out_stall = 1'b0;
	logic has_byte;
	logic [7:0] out_byte;
	logic [1:0] want;
	logic cfg_we;
	logic cfg_index;
	logic [SIZE_W-1:0] cfg_wdata;

	// decoder state as the stream should leave it
	phase_t dec_phase = PH_FLAG;
	logic [15:0] ctrl_word = '0;
	logic [4:0] ctrl_left = '0;
	logic [SIZE_W-1:0] n_packed = '0;
	logic [SIZE_W-1:0] n_out = '0;
	logic [SIZE_W-1:0] cfg_packed = '0;
	logic [SIZE_W-1:0] cfg_raw = '0;
	logic [7:0] hist [WINDOW_DEPTH_DEF];
	logic [3:0] tok_code = '0;
	logic [CNT_W-1:0] run_left = '0;
	logic [CNT_W-1:0] copy_dist = '0;
	logic [7:0] fill = '0;
	logic err = 1'b0;

	decoded_t decoded_q[$];
	int bad_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int stall_hold = 0;
	int quiet = 0;
	logic [7:0] plan_hi = '0;
	logic [7:0] plan_len = '0;
	int idle_mix[4] = '{0, 67, 0, 14};
	int stall_mix[4] = '{0, 0, 67, 14};
	ending_t ending;

	rdc_lz_rle_decompressor_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void flag_error();
		err = 1'b1;
		dec_phase = PH_END;
	endfunction

	// Resolve a token boundary and check that the wanted byte exists.
	function automatic void resolve_boundary();
		if (dec_phase == PH_FLAG) begin
			if (n_out == cfg_raw) begin
				dec_phase = PH_END;
				return;
			end
			if (ctrl_left == 5'd0) begin
				dec_phase = PH_CTRL_HI;
			end else begin
				dec_phase = ctrl_word[15] ? PH_TOKEN : PH_LIT;
				ctrl_word = {ctrl_word[14:0], 1'b0};
				ctrl_left = ctrl_left - 5'd1;
			end
		end
		if (dec_phase == PH_CTRL_HI) begin
			if ({1'b0, n_packed} + 25'd1 >= {1'b0, cfg_packed}) flag_error();
		end else if (dec_phase >= PH_CTRL_LO && dec_phase <= PH_CP_LONG) begin
			if (n_packed >= cfg_packed) flag_error();
		end
	endfunction

	function automatic void begin_copy();
		if (SIZE_W'(copy_dist) > n_out
				|| {1'b0, n_out} + 25'(run_left) > {1'b0, cfg_raw}) flag_error();
		else dec_phase = PH_COPY;
	endfunction

	function automatic decoded_t decode_item(input logic o, input logic [7:0] b);
		decoded_t r;
		logic emitted;
		logic [7:0] v;
		phase_t ph;
		r = '0;
		emitted = 1'b0;
		v = '0;
		resolve_boundary();
		ph = dec_phase;
		if (o == OP_BYTE && ph >= PH_CTRL_HI && ph <= PH_CP_LONG) begin
			n_packed = n_packed + 24'd1;
			case (ph)
				PH_CTRL_HI: begin
					ctrl_word = {b, 8'h00};
					dec_phase = PH_CTRL_LO;
				end
				PH_CTRL_LO: begin
					ctrl_word[7:0] = b;
					ctrl_left = CTRL_BITS;
					dec_phase = PH_FLAG;
				end
				PH_LIT: begin
					emitted = 1'b1;
					v = b;
					dec_phase = PH_FLAG;
				end
				PH_TOKEN: begin
					tok_code = b[7:4];
					if (tok_code == CODE_SHORT_RUN) begin
						run_left = CNT_W'(b[3:0]) + SHORT_RUN_BIAS;
						dec_phase = PH_RS_CHAR;
					end else if (tok_code == CODE_LONG_RUN) begin
						run_left = CNT_W'(b[3:0]);
						dec_phase = PH_RL_HI;
					end else begin
						copy_dist = CNT_W'(b[3:0]);
						dec_phase = PH_CP_DIST;
					end
				end
				PH_RS_CHAR, PH_RL_CHAR: begin
					fill = b;
					if ({1'b0, n_out} + 25'(run_left) > {1'b0, cfg_raw}) flag_error();
					else dec_phase = PH_RUN;
				end
				PH_RL_HI: begin
					run_left = (run_left | CNT_W'({b, 4'h0})) + LONG_RUN_BIAS;
					dec_phase = PH_RL_CHAR;
				end
				PH_CP_DIST: begin
					copy_dist = (copy_dist | CNT_W'({b, 4'h0})) + DIST_BIAS;
					if (tok_code == CODE_LONG_COPY) begin
						dec_phase = PH_CP_LONG;
					end else begin
						run_left = CNT_W'(tok_code);
						begin_copy();
					end
				end
				default: begin
					run_left = CNT_W'(b) + LONG_COPY_BIAS;
					begin_copy();
				end
			endcase
		end else if (o == OP_ADV && (ph == PH_RUN || ph == PH_COPY)) begin
			emitted = 1'b1;
			v = (ph == PH_RUN) ? fill : hist[n_out[CNT_W-1:0] - copy_dist];
			run_left = run_left - CNT_W'(1);
			if (run_left == '0) dec_phase = PH_FLAG;
		end
		if (emitted) begin
			hist[n_out[CNT_W-1:0]] = v;
			n_out = n_out + 24'd1;
			r.has_byte = 1'b1;
			r.data = v;
		end
		resolve_boundary();
		if (dec_phase == PH_END) r.want = err ? WANT_ERR : WANT_DONE;
		else if (dec_phase == PH_RUN || dec_phase == PH_COPY) r.want = WANT_ADV;
		else r.want = WANT_BYTE;
		return r;
	endfunction

	task automatic send(input logic o, input logic [7:0] b);
		in_valid <= 1'b1;
		op <= o;
		byte_in <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decoded_q.push_back(decode_item(o, b));
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Pick the next request from where the stream stands, mostly well formed.
	task automatic send_next();
		logic o;
		logic [7:0] b;
		int unsigned kind;
		int unsigned lim;
		int unsigned d;
		o = (dec_phase == PH_RUN || dec_phase == PH_COPY) ? OP_ADV : OP_BYTE;
		b = 8'($urandom_range(255));
		if ($urandom_range(99) < 5) begin
			o = ~o;
		end else if (o == OP_BYTE) begin
			case (dec_phase)
				PH_TOKEN: begin
					kind = $urandom_range(99);
					if (n_out < 3 || kind < 30) begin
						b[7:4] = CODE_SHORT_RUN;
					end else if (kind < 45) begin
						b[7:4] = CODE_LONG_RUN;
						plan_hi = ($urandom_range(9) == 0) ? 8'($urandom_range(3)) : 8'd0;
					end else begin
						lim = (n_out > 4098) ? 4098 : n_out;
						if ($urandom_range(3) == 0) d = $urandom_range(lim, 3);
						else d = $urandom_range((lim < 40) ? lim : 40, 3);
						d = d - 3;
						b[3:0] = d[3:0];
						plan_hi = d[11:4];
						if (kind < 60) begin
							b[7:4] = CODE_LONG_COPY;
							plan_len = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
								: 8'($urandom_range(15));
						end else begin
							b[7:4] = 4'($urandom_range(15, CODE_SHORT_COPY_MIN));
						end
					end
				end
				PH_RL_HI, PH_CP_DIST: b = plan_hi;
				PH_CP_LONG: b = plan_len;
				default: ;
			endcase
		end
		send(o, b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	task automatic program_sizes(input logic [SIZE_W-1:0] p, input logic [SIZE_W-1:0] r);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PACKED_SIZE;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_index <= CFG_RAW_SIZE;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_packed = p;
		cfg_raw = r;
		@(posedge clk);
	endtask

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		// control word: literal, literal, then three commands
		send(OP_BYTE, 8'h38);
		send(OP_BYTE, 8'h00);
		send(OP_BYTE, 8'h00);
		send(OP_ADV, 8'hFF);
		send(OP_BYTE, 8'hFF);
		send(OP_BYTE, {CODE_SHORT_RUN, 4'h0});
		send(OP_BYTE, 8'hC3);
		send(OP_ADV, 8'h00);
		send(OP_BYTE, 8'h5A);
		repeat (2) send(OP_ADV, 8'h00);
		send(OP_BYTE, {CODE_SHORT_COPY_MIN, 4'h0});
		send(OP_BYTE, 8'h00);
		repeat (3) send(OP_ADV, 8'hFF);
		send(OP_BYTE, 8'h45);
		send(OP_BYTE, 8'h00);
		repeat (4) send(OP_ADV, 8'h00);
		drain();
	endtask

	task automatic test_random();
		for (int i = 0; i < 4; i++) begin
			idle_pct = idle_mix[i];
			stall_pct = stall_mix[i];
			repeat (250) send_next();
			drain();
			program_sizes(SIZE_W'($urandom_range(24'hFFFFFF, n_packed + 20000)),
				SIZE_W'($urandom_range(24'hFFFFFF, n_out + 20000)));
		end
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 14;
		stall_hold = HOLD_CYCLES;
		repeat (40) send_next();
		drain();
	endtask

	task automatic test_largest();
		logic [11:0] fld;
		idle_pct = 14;
		stall_pct = 14;
		while (dec_phase != PH_TOKEN) send_next();
		send(OP_BYTE, {CODE_LONG_RUN, 4'hF});
		send(OP_BYTE, 8'h08);
		send(OP_BYTE, 8'($urandom_range(255)));
		while (dec_phase == PH_RUN) send(OP_ADV, 8'($urandom_range(255)));
		while (dec_phase != PH_TOKEN) send_next();
		// longest copy from the farthest distance the output allows
		fld = 12'(((n_out > 24'd4098) ? 24'd4098 : n_out) - 24'd3);
		send(OP_BYTE, {CODE_LONG_COPY, fld[3:0]});
		send(OP_BYTE, fld[11:4]);
		send(OP_BYTE, 8'hFF);
		while (dec_phase == PH_COPY) send(OP_ADV, 8'($urandom_range(255)));
		drain();
	endtask

	task automatic test_ending();
		logic [11:0] fld;
		idle_pct = 14;
		stall_pct = 14;
		case (ending)
			END_DONE: begin
				while (dec_phase != PH_LIT) send_next();
				drain();
				program_sizes(cfg_packed, n_out + 24'd1);
				send(OP_BYTE, 8'($urandom_range(255)));
			end
			END_TRUNCATED: begin
				while (dec_phase != PH_LIT) send_next();
				drain();
				program_sizes('0, cfg_raw);
				send(OP_BYTE, 8'($urandom_range(255)));
			end
			END_OVERFLOW: begin
				while (dec_phase != PH_TOKEN) send_next();
				drain();
				program_sizes(cfg_packed, n_out + 24'd2);
				send(OP_BYTE, {CODE_SHORT_RUN, 4'h0});
				send(OP_BYTE, 8'($urandom_range(255)));
			end
			default: begin
				while (dec_phase != PH_TOKEN) send_next();
				// distance one past the bytes produced so far
				fld = 12'(n_out - 24'd2);
				send(OP_BYTE, {CODE_SHORT_COPY_MIN, fld[3:0]});
				send(OP_BYTE, fld[11:4]);
			end
		endcase
		// the decoder is stuck now; drop everything, even after new sizes
		repeat (4) send(1'($urandom_range(1)), 8'($urandom_range(255)));
		drain();
		program_sizes(24'hFFFFFF, 24'hFFFFFF);
		repeat (4) send(1'($urandom_range(1)), 8'($urandom_range(255)));
		drain();
	endtask

	always @(posedge clk) begin
		decoded_t head;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected result: has_byte %0b out_byte %02h want %0d",
						has_byte, out_byte, want);
			end else begin
				head = decoded_q.pop_front();
				if (has_byte !== head.has_byte || out_byte !== head.data
						|| want !== head.want) begin
					bad_count++;
					if (bad_count <= 10)
						$display("mismatch: expected %0b/%02h/%0d got %0b/%02h/%0d",
							head.has_byte, head.data, head.want,
							has_byte, out_byte, want);
				end
			end
		end
	end

	// hold the receiver off for a counted stretch, otherwise stall at random
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			out_stall <= 1'b1;
			stall_hold--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_BYTE;
		byte_in <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PACKED_SIZE;
		cfg_wdata <= '0;
		ending = ending_t'($urandom_range(3));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		program_sizes(24'hFFFFFF, 24'hFFFFFF);
		test_directed();
		test_random();
		test_backpressure();
		// a copy reaching past the output needs a short history
		if (ending != END_TOO_FAR) test_largest();
		test_ending();
		drain();
		repeat (4) @(posedge clk);
		if (bad_count == 0 && decoded_q.size() == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
